>>> hdl/vud_pkg.sv
// Shared types and constants for the unsigned 32-bit varint stream decoder.
`default_nettype none

package vud_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned PART_W   = 28;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned DIGIT_W  = 7;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd4;
    localparam int unsigned        CONT_BIT   = 7;
    localparam logic [COUNT_W-1:0] MAX_COUNT  = 3'd5;

    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
        logic [PART_W-1:0]    partial_next;
        logic [INDEX_W-1:0]   index_next;
    } step_result_t;

endpackage

`default_nettype wire

>>> hdl/vud_step.sv
// Combinational decode of one stream byte against the partial value and byte index.
`default_nettype none

module vud_step (
    input  wire logic [vud_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic [vud_pkg::PART_W-1:0]  partial,
    input  wire logic [vud_pkg::INDEX_W-1:0] index,
    output vud_pkg::step_result_t            result
);
    import vud_pkg::*;

    logic [PART_W-1:0] digit;
    logic [PART_W-1:0] shifted;
    logic [PART_W-1:0] acc;

    assign digit = {{(PART_W-DIGIT_W){1'b0}}, data_byte[DIGIT_W-1:0]};

    always_comb
    begin
        unique case (index)
            3'd0:    shifted = digit;
            3'd1:    shifted = digit << DIGIT_W;
            3'd2:    shifted = digit << (2*DIGIT_W);
            3'd3:    shifted = digit << (3*DIGIT_W);
            default: shifted = '0;
        endcase
    end

    assign acc = partial | shifted;

    always_comb
    begin
        result = '0;
        priority if (index >= LAST_INDEX)
        begin
            // fifth byte: keep only its low nibble, ignore continuation
            result.done         = 1'b1;
            result.value        = {data_byte[3:0], partial};
            result.count        = MAX_COUNT;
            result.partial_next = '0;
            result.index_next   = '0;
        end
        else if (data_byte[CONT_BIT])
        begin
            result.done         = 1'b0;
            result.value        = '0;
            result.count        = '0;
            result.partial_next = acc;
            result.index_next   = index + 3'd1;
        end
        else
        begin
            result.done         = 1'b1;
            result.value        = {{(VALUE_W-PART_W){1'b0}}, acc};
            result.count        = index + 3'd1;
            result.partial_next = '0;
            result.index_next   = '0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/varint_u32_stream_decoder.sv
// Top level of the unsigned 32-bit varint (LEB128-style) stream decoder.
//
// Input channel: one encoded byte per transaction on data_byte, taken when
// in_valid is high and in_stall is low. Bit 7 set means more bytes follow.
// Output channel: one transaction per finished value on decoded_value and
// byte_count (1 to 5), offered while out_valid is high and taken when
// out_stall is low. Bytes that continue a value produce no transaction.
// A value ends on the first byte with bit 7 clear, or always on the fifth.
// Throughput: one byte per cycle while in_stall is low. The byte lands in an
// input register, is decoded by one shift/OR/count step, and the result lands
// in the output register, from which it is offered on out_valid.
// When the receiver stalls, the output register holds; the input register
// still drains into the partial value for continuation bytes, and in_stall
// rises only when a held byte would need the occupied output register.
// Reset clears the partial value, the byte index and both valid flags, so
// decoding restarts at the start of a value.
`default_nettype none

module varint_u32_stream_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [vud_pkg::BYTE_W-1:0]    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [vud_pkg::VALUE_W-1:0]        decoded_value,
    output logic [vud_pkg::COUNT_W-1:0]        byte_count
);
    import vud_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [PART_W-1:0]   partial_reg;
    logic [PART_W-1:0]   partial_next;
    logic [INDEX_W-1:0]  index_reg;
    logic [INDEX_W-1:0]  index_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [COUNT_W-1:0]  count_reg;

    step_result_t        step;
    logic                out_free;
    logic                blocked;
    logic                fire;

    vud_step u_step (
        .data_byte (byte_reg),
        .partial   (partial_reg),
        .index     (index_reg),
        .result    (step)
    );

    assign out_free = !out_valid_reg || !out_stall;
    // only a finishing byte needs the output register
    assign blocked  = in_valid_reg && step.done && !out_free;
    assign fire     = in_valid_reg && !blocked;
    assign in_stall = blocked;

    always_comb
    begin
        partial_next   = partial_reg;
        index_next     = index_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            partial_next = step.partial_next;
            index_next   = step.index_next;
            if (step.done)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            partial_reg   <= '0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!blocked)
            begin
                in_valid_reg <= in_valid;
            end
            partial_reg   <= partial_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !blocked)
        begin
            byte_reg <= data_byte;
        end
        if (fire && step.done)
        begin
            value_reg <= step.value;
            count_reg <= step.count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign decoded_value = value_reg;
    assign byte_count    = count_reg;

endmodule

`default_nettype wire
